[rtl/sfc_pkg.sv]
// Shared types, property masks, opcodes and rule helpers for the fragment type checker.
package sfc_pkg;

	typedef logic [18:0] ptype_t;

	localparam int unsigned MAX_CHILDREN_DEF = 64;
	localparam logic [31:0] LOCKTIME_RESET = 32'd500000000;

	localparam int unsigned CFG_TAPSCRIPT = 0;
	localparam int unsigned CFG_LOCKTIME  = 1;

	localparam int unsigned SEQ_TYPE_BIT = 22;
	localparam int unsigned TSHIFT = 14;

	localparam ptype_t P_K  = 19'h00001;
	localparam ptype_t P_V  = 19'h00002;
	localparam ptype_t P_B  = 19'h00004;
	localparam ptype_t P_W  = 19'h00008;
	localparam ptype_t P_Z  = 19'h00010;
	localparam ptype_t P_O  = 19'h00020;
	localparam ptype_t P_N  = 19'h00040;
	localparam ptype_t P_D  = 19'h00080;
	localparam ptype_t P_U  = 19'h00100;
	localparam ptype_t P_E  = 19'h00200;
	localparam ptype_t P_F  = 19'h00400;
	localparam ptype_t P_S  = 19'h00800;
	localparam ptype_t P_M  = 19'h01000;
	localparam ptype_t P_X  = 19'h02000;
	localparam ptype_t P_G  = 19'h04000;
	localparam ptype_t P_H  = 19'h08000;
	localparam ptype_t P_I  = 19'h10000;
	localparam ptype_t P_J  = 19'h20000;
	localparam ptype_t P_KT = 19'h40000;
	localparam ptype_t P_GHIJ  = P_G | P_H | P_I | P_J;
	localparam ptype_t P_GHIJK = P_GHIJ | P_KT;

	typedef enum logic [4:0] {
		OP_PK_K      = 5'd0,
		OP_PK_H      = 5'd1,
		OP_OLDER     = 5'd2,
		OP_AFTER     = 5'd3,
		OP_SHA256    = 5'd4,
		OP_RIPEMD160 = 5'd5,
		OP_HASH256   = 5'd6,
		OP_HASH160   = 5'd7,
		OP_JUST_1    = 5'd8,
		OP_JUST_0    = 5'd9,
		OP_WRAP_A    = 5'd10,
		OP_WRAP_S    = 5'd11,
		OP_WRAP_C    = 5'd12,
		OP_WRAP_D    = 5'd13,
		OP_WRAP_V    = 5'd14,
		OP_WRAP_J    = 5'd15,
		OP_WRAP_N    = 5'd16,
		OP_AND_V     = 5'd17,
		OP_AND_B     = 5'd18,
		OP_OR_B      = 5'd19,
		OP_OR_D      = 5'd20,
		OP_OR_C      = 5'd21,
		OP_OR_I      = 5'd22,
		OP_ANDOR     = 5'd23,
		OP_MULTI     = 5'd24,
		OP_MULTI_A   = 5'd25,
		OP_THRESH    = 5'd26
	} opcode_t;

	// Position flags of one threshold child.
	typedef struct packed {
		logic first;
		logic last;
	} thr_ctl_t;

	function automatic logic f_has(ptype_t t, ptype_t m);
		return (t & m) == m;
	endfunction

	function automatic ptype_t f_iff(logic c, ptype_t v);
		return c ? v : '0;
	endfunction

	function automatic logic f_conflict(ptype_t a, ptype_t b);
		return (f_has(a, P_G) && f_has(b, P_H)) || (f_has(a, P_H) && f_has(b, P_G)) ||
			(f_has(a, P_I) && f_has(b, P_J)) || (f_has(a, P_J) && f_has(b, P_I));
	endfunction

	function automatic ptype_t f_orule(ptype_t x, ptype_t y);
		return f_iff(f_has(x | y, P_Z), (x | y) & P_O);
	endfunction

	function automatic ptype_t f_nrule(ptype_t x, ptype_t y);
		return (x & P_N) | f_iff(f_has(x, P_Z), y & P_N);
	endfunction

	function automatic ptype_t f_ktl(ptype_t x, ptype_t y, ptype_t both);
		return f_iff(f_has(both, P_KT) && !f_conflict(x, y), P_KT);
	endfunction

endpackage

[rtl/sfc_rules.sv]
// Property-set rules for every single-item fragment kind (leaves, wrappers, and/or, multi).
module sfc_rules (
	input  logic [4:0]      opcode,
	input  sfc_pkg::ptype_t x,
	input  sfc_pkg::ptype_t y,
	input  sfc_pkg::ptype_t z,
	input  logic [31:0]     k,
	input  logic            tapscript_mode,
	input  logic [31:0]     lock_boundary,
	output sfc_pkg::ptype_t result
);

	sfc_pkg::ptype_t w;
	logic            sf;
	logic            k_late;

	assign w      = x | (y & z);
	assign sf     = sfc_pkg::f_has(x, sfc_pkg::P_S) || sfc_pkg::f_has(y, sfc_pkg::P_F);
	assign k_late = (k >= lock_boundary);

	always_comb begin
		case (opcode)
			sfc_pkg::OP_PK_K: begin
				result = sfc_pkg::P_K | sfc_pkg::P_O | sfc_pkg::P_N | sfc_pkg::P_U |
					sfc_pkg::P_D | sfc_pkg::P_E | sfc_pkg::P_M | sfc_pkg::P_S |
					sfc_pkg::P_X | sfc_pkg::P_KT;
			end
			sfc_pkg::OP_PK_H: begin
				result = sfc_pkg::P_K | sfc_pkg::P_N | sfc_pkg::P_U | sfc_pkg::P_D |
					sfc_pkg::P_E | sfc_pkg::P_M | sfc_pkg::P_S | sfc_pkg::P_X |
					sfc_pkg::P_KT;
			end
			sfc_pkg::OP_OLDER: begin
				result = (k[sfc_pkg::SEQ_TYPE_BIT] ? sfc_pkg::P_G : sfc_pkg::P_H) |
					sfc_pkg::P_B | sfc_pkg::P_Z | sfc_pkg::P_F | sfc_pkg::P_M |
					sfc_pkg::P_X | sfc_pkg::P_KT;
			end
			sfc_pkg::OP_AFTER: begin
				result = (k_late ? sfc_pkg::P_I : sfc_pkg::P_J) |
					sfc_pkg::P_B | sfc_pkg::P_Z | sfc_pkg::P_F | sfc_pkg::P_M |
					sfc_pkg::P_X | sfc_pkg::P_KT;
			end
			sfc_pkg::OP_SHA256, sfc_pkg::OP_RIPEMD160,
			sfc_pkg::OP_HASH256, sfc_pkg::OP_HASH160: begin
				result = sfc_pkg::P_B | sfc_pkg::P_O | sfc_pkg::P_N | sfc_pkg::P_U |
					sfc_pkg::P_D | sfc_pkg::P_M | sfc_pkg::P_KT;
			end
			sfc_pkg::OP_JUST_1: begin
				result = sfc_pkg::P_B | sfc_pkg::P_Z | sfc_pkg::P_U | sfc_pkg::P_F |
					sfc_pkg::P_M | sfc_pkg::P_X | sfc_pkg::P_KT;
			end
			sfc_pkg::OP_JUST_0: begin
				result = sfc_pkg::P_B | sfc_pkg::P_Z | sfc_pkg::P_U | sfc_pkg::P_D |
					sfc_pkg::P_E | sfc_pkg::P_M | sfc_pkg::P_S | sfc_pkg::P_X |
					sfc_pkg::P_KT;
			end
			sfc_pkg::OP_WRAP_A: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_B), sfc_pkg::P_W) |
					(x & sfc_pkg::P_GHIJK) |
					(x & (sfc_pkg::P_U | sfc_pkg::P_D | sfc_pkg::P_F | sfc_pkg::P_E |
					sfc_pkg::P_M | sfc_pkg::P_S)) | sfc_pkg::P_X;
			end
			sfc_pkg::OP_WRAP_S: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_B | sfc_pkg::P_O),
					sfc_pkg::P_W) | (x & sfc_pkg::P_GHIJK) |
					(x & (sfc_pkg::P_U | sfc_pkg::P_D | sfc_pkg::P_F | sfc_pkg::P_E |
					sfc_pkg::P_M | sfc_pkg::P_S | sfc_pkg::P_X));
			end
			sfc_pkg::OP_WRAP_C: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_K), sfc_pkg::P_B) |
					(x & sfc_pkg::P_GHIJK) |
					(x & (sfc_pkg::P_O | sfc_pkg::P_N | sfc_pkg::P_D | sfc_pkg::P_F |
					sfc_pkg::P_E | sfc_pkg::P_M)) | sfc_pkg::P_U | sfc_pkg::P_S;
			end
			sfc_pkg::OP_WRAP_D: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_V | sfc_pkg::P_Z),
					sfc_pkg::P_B) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_Z), sfc_pkg::P_O) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_F), sfc_pkg::P_E) |
					(x & sfc_pkg::P_GHIJK) | (x & (sfc_pkg::P_M | sfc_pkg::P_S)) |
					sfc_pkg::f_iff(tapscript_mode, sfc_pkg::P_U) |
					sfc_pkg::P_N | sfc_pkg::P_D | sfc_pkg::P_X;
			end
			sfc_pkg::OP_WRAP_V: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_B), sfc_pkg::P_V) |
					(x & sfc_pkg::P_GHIJK) |
					(x & (sfc_pkg::P_Z | sfc_pkg::P_O | sfc_pkg::P_N | sfc_pkg::P_M |
					sfc_pkg::P_S)) | sfc_pkg::P_F | sfc_pkg::P_X;
			end
			sfc_pkg::OP_WRAP_J: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_B | sfc_pkg::P_N),
					sfc_pkg::P_B) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_F), sfc_pkg::P_E) |
					(x & sfc_pkg::P_GHIJK) |
					(x & (sfc_pkg::P_O | sfc_pkg::P_U | sfc_pkg::P_M | sfc_pkg::P_S)) |
					sfc_pkg::P_N | sfc_pkg::P_D | sfc_pkg::P_X;
			end
			sfc_pkg::OP_WRAP_N: begin
				result = (x & sfc_pkg::P_GHIJK) |
					(x & (sfc_pkg::P_B | sfc_pkg::P_Z | sfc_pkg::P_O | sfc_pkg::P_N |
					sfc_pkg::P_D | sfc_pkg::P_F | sfc_pkg::P_E | sfc_pkg::P_M |
					sfc_pkg::P_S)) | sfc_pkg::P_U | sfc_pkg::P_X;
			end
			sfc_pkg::OP_AND_V: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_V),
					y & (sfc_pkg::P_K | sfc_pkg::P_V | sfc_pkg::P_B)) |
					sfc_pkg::f_nrule(x, y) | sfc_pkg::f_orule(x, y) |
					(x & y & (sfc_pkg::P_D | sfc_pkg::P_M | sfc_pkg::P_Z)) |
					((x | y) & sfc_pkg::P_S) |
					sfc_pkg::f_iff(sfc_pkg::f_has(y, sfc_pkg::P_F) ||
					sfc_pkg::f_has(x, sfc_pkg::P_S), sfc_pkg::P_F) |
					(y & (sfc_pkg::P_U | sfc_pkg::P_X)) | ((x | y) & sfc_pkg::P_GHIJ) |
					sfc_pkg::f_ktl(x, y, x & y);
			end
			sfc_pkg::OP_AND_B: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(y, sfc_pkg::P_W), x & sfc_pkg::P_B) |
					sfc_pkg::f_orule(x, y) | sfc_pkg::f_nrule(x, y) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x & y, sfc_pkg::P_S),
					x & y & sfc_pkg::P_E) |
					(x & y & (sfc_pkg::P_D | sfc_pkg::P_Z | sfc_pkg::P_M)) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x & y, sfc_pkg::P_F) ||
					sfc_pkg::f_has(x, sfc_pkg::P_S | sfc_pkg::P_F) ||
					sfc_pkg::f_has(y, sfc_pkg::P_S | sfc_pkg::P_F), sfc_pkg::P_F) |
					((x | y) & sfc_pkg::P_S) | sfc_pkg::P_U | sfc_pkg::P_X |
					((x | y) & sfc_pkg::P_GHIJ) | sfc_pkg::f_ktl(x, y, x & y);
			end
			sfc_pkg::OP_OR_B: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_B | sfc_pkg::P_D) &&
					sfc_pkg::f_has(y, sfc_pkg::P_W | sfc_pkg::P_D), sfc_pkg::P_B) |
					sfc_pkg::f_orule(x, y) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x | y, sfc_pkg::P_S) &&
					sfc_pkg::f_has(x & y, sfc_pkg::P_E), x & y & sfc_pkg::P_M) |
					(x & y & (sfc_pkg::P_Z | sfc_pkg::P_S | sfc_pkg::P_E)) |
					sfc_pkg::P_D | sfc_pkg::P_U | sfc_pkg::P_X |
					((x | y) & sfc_pkg::P_GHIJ) | (x & y & sfc_pkg::P_KT);
			end
			sfc_pkg::OP_OR_D: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_B | sfc_pkg::P_D |
					sfc_pkg::P_U), y & sfc_pkg::P_B) |
					sfc_pkg::f_iff(sfc_pkg::f_has(y, sfc_pkg::P_Z), x & sfc_pkg::P_O) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_E) &&
					sfc_pkg::f_has(x | y, sfc_pkg::P_S), x & y & sfc_pkg::P_M) |
					(x & y & (sfc_pkg::P_Z | sfc_pkg::P_S)) |
					(y & (sfc_pkg::P_U | sfc_pkg::P_F | sfc_pkg::P_D | sfc_pkg::P_E)) |
					sfc_pkg::P_X | ((x | y) & sfc_pkg::P_GHIJ) | (x & y & sfc_pkg::P_KT);
			end
			sfc_pkg::OP_OR_C: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_B | sfc_pkg::P_D |
					sfc_pkg::P_U), y & sfc_pkg::P_V) |
					sfc_pkg::f_iff(sfc_pkg::f_has(y, sfc_pkg::P_Z), x & sfc_pkg::P_O) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_E) &&
					sfc_pkg::f_has(x | y, sfc_pkg::P_S), x & y & sfc_pkg::P_M) |
					(x & y & (sfc_pkg::P_Z | sfc_pkg::P_S)) |
					sfc_pkg::P_F | sfc_pkg::P_X | ((x | y) & sfc_pkg::P_GHIJ) |
					(x & y & sfc_pkg::P_KT);
			end
			sfc_pkg::OP_OR_I: begin
				result = (x & y & (sfc_pkg::P_V | sfc_pkg::P_B | sfc_pkg::P_K |
					sfc_pkg::P_U | sfc_pkg::P_F | sfc_pkg::P_S)) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x & y, sfc_pkg::P_Z), sfc_pkg::P_O) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x | y, sfc_pkg::P_F),
					(x | y) & sfc_pkg::P_E) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x | y, sfc_pkg::P_S),
					x & y & sfc_pkg::P_M) |
					((x | y) & sfc_pkg::P_D) | sfc_pkg::P_X |
					((x | y) & sfc_pkg::P_GHIJ) | (x & y & sfc_pkg::P_KT);
			end
			sfc_pkg::OP_ANDOR: begin
				result = sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_B | sfc_pkg::P_D |
					sfc_pkg::P_U), y & z & (sfc_pkg::P_B | sfc_pkg::P_K | sfc_pkg::P_V)) |
					(x & y & z & sfc_pkg::P_Z) |
					sfc_pkg::f_iff(sfc_pkg::f_has(w, sfc_pkg::P_Z), w & sfc_pkg::P_O) |
					(y & z & sfc_pkg::P_U) | sfc_pkg::f_iff(sf, z & sfc_pkg::P_F) |
					(z & sfc_pkg::P_D) | sfc_pkg::f_iff(sf, z & sfc_pkg::P_E) |
					sfc_pkg::f_iff(sfc_pkg::f_has(x, sfc_pkg::P_E) &&
					sfc_pkg::f_has(x | y | z, sfc_pkg::P_S), x & y & z & sfc_pkg::P_M) |
					(z & (x | y) & sfc_pkg::P_S) | sfc_pkg::P_X |
					((x | y | z) & sfc_pkg::P_GHIJ) | sfc_pkg::f_ktl(x, y, x & y & z);
			end
			sfc_pkg::OP_MULTI: begin
				result = sfc_pkg::P_B | sfc_pkg::P_N | sfc_pkg::P_U | sfc_pkg::P_D |
					sfc_pkg::P_E | sfc_pkg::P_M | sfc_pkg::P_S | sfc_pkg::P_KT;
			end
			sfc_pkg::OP_MULTI_A: begin
				result = sfc_pkg::P_B | sfc_pkg::P_U | sfc_pkg::P_D | sfc_pkg::P_E |
					sfc_pkg::P_M | sfc_pkg::P_S | sfc_pkg::P_KT;
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule

[rtl/sfc_thresh.sv]
// Threshold accumulator: folds one child per beat and forms the set on the last child.
module sfc_thresh #(
	parameter int unsigned MAX_CHILDREN = sfc_pkg::MAX_CHILDREN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sfc_pkg::thr_ctl_t ctl,
	input  sfc_pkg::ptype_t   x,
	input  logic [31:0]       k,
	input  logic [6:0]        child_count,
	output sfc_pkg::ptype_t   result
);

	localparam int unsigned NumW = $clog2(MAX_CHILDREN + 1);
	localparam int unsigned CmpW = 34;

	logic            all_e_q, all_m_q, failed_q;
	logic [1:0]      args_q;
	logic [NumW-1:0] num_s_q;
	logic [4:0]      tl_q;

	logic            all_e_b, all_m_b, failed_b;
	logic [1:0]      args_b;
	logic [NumW-1:0] num_s_b;
	logic [4:0]      tl_b;

	logic            all_e_n, all_m_n, failed_n;
	logic [1:0]      args_n;
	logic [NumW-1:0] num_s_n;
	logic [4:0]      tl_n;

	logic            ok;
	logic [1:0]      add;
	logic [2:0]      args_sum;
	sfc_pkg::ptype_t tl_wide;
	logic            kt_keep;

	logic signed [CmpW-1:0] ns, nn, nk;

	// Start from reset values on the first child, otherwise from the running state.
	always_comb begin
		if (ctl.first) begin
			all_e_b  = 1'b1;
			all_m_b  = 1'b1;
			args_b   = '0;
			num_s_b  = '0;
			tl_b     = 5'b10000;
			failed_b = 1'b0;
		end else begin
			all_e_b  = all_e_q;
			all_m_b  = all_m_q;
			args_b   = args_q;
			num_s_b  = num_s_q;
			tl_b     = tl_q;
			failed_b = failed_q;
		end
	end

	assign ok = ctl.first ?
		sfc_pkg::f_has(x, sfc_pkg::P_B | sfc_pkg::P_D | sfc_pkg::P_U) :
		sfc_pkg::f_has(x, sfc_pkg::P_W | sfc_pkg::P_D | sfc_pkg::P_U);

	assign add = sfc_pkg::f_has(x, sfc_pkg::P_Z) ? 2'd0 :
		(sfc_pkg::f_has(x, sfc_pkg::P_O) ? 2'd1 : 2'd2);
	assign args_sum = {1'b0, args_b} + {1'b0, add};

	assign tl_wide = {tl_b, 14'b0};
	assign kt_keep = tl_b[4] && x[18] &&
		((k <= 32'd1) || !sfc_pkg::f_conflict(tl_wide, x));

	always_comb begin
		all_e_n  = all_e_b;
		all_m_n  = all_m_b;
		args_n   = args_b;
		num_s_n  = num_s_b;
		tl_n     = tl_b;
		failed_n = failed_b;
		if (!failed_b) begin
			if (!ok) begin
				failed_n = 1'b1;
			end else begin
				if (!sfc_pkg::f_has(x, sfc_pkg::P_E)) begin
					all_e_n = 1'b0;
				end
				if (!sfc_pkg::f_has(x, sfc_pkg::P_M)) begin
					all_m_n = 1'b0;
				end
				if (sfc_pkg::f_has(x, sfc_pkg::P_S) &&
						(num_s_b < NumW'(MAX_CHILDREN))) begin
					num_s_n = NumW'(num_s_b + 1'b1);
				end
				args_n = (args_sum > 3'd2) ? 2'd2 : args_sum[1:0];
				tl_n   = {kt_keep, tl_b[3:0] | x[17:14]};
			end
		end
	end

	// Signed count checks: n - k may go negative.
	assign ns = {{(CmpW-NumW){1'b0}}, num_s_n};
	assign nn = {{(CmpW-7){1'b0}}, child_count};
	assign nk = nn - {2'b0, k};

	always_comb begin
		if (failed_n) begin
			result = '0;
		end else begin
			result = sfc_pkg::P_B | sfc_pkg::P_D | sfc_pkg::P_U |
				sfc_pkg::f_iff(args_n == 2'd0, sfc_pkg::P_Z) |
				sfc_pkg::f_iff(args_n == 2'd1, sfc_pkg::P_O) |
				sfc_pkg::f_iff(all_e_n && (ns == nn), sfc_pkg::P_E) |
				sfc_pkg::f_iff(all_e_n && all_m_n && (ns >= nk), sfc_pkg::P_M) |
				sfc_pkg::f_iff(ns >= nk + 1, sfc_pkg::P_S) |
				{tl_n, 14'b0};
		end
	end

	// Advance the running state; the last child returns it to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_e_q  <= 1'b1;
			all_m_q  <= 1'b1;
			args_q   <= '0;
			num_s_q  <= '0;
			tl_q     <= 5'b10000;
			failed_q <= 1'b0;
		end else if (step) begin
			if (ctl.last) begin
				all_e_q  <= 1'b1;
				all_m_q  <= 1'b1;
				args_q   <= '0;
				num_s_q  <= '0;
				tl_q     <= 5'b10000;
				failed_q <= 1'b0;
			end else begin
				all_e_q  <= all_e_n;
				all_m_q  <= all_m_n;
				args_q   <= args_n;
				num_s_q  <= num_s_n;
				tl_q     <= tl_n;
				failed_q <= failed_n;
			end
		end
	end

endmodule

[rtl/script_fragment_type_check.sv]
// Top level of the script fragment type checker: input stage, rule logic, result register.
// Computes the 19-bit property set (K V B W z o n d u e f s m x g h i j k, bit 0 first) of a
// script fragment. Each input beat carries an opcode and the children's property sets; leaf,
// wrapper, and/or, andor and multi kinds give one result beat per input beat. A threshold is
// fed one child per beat (first_child on the first, last_child on the last) and gives a single
// result beat on its last child; earlier children give none. Unknown opcodes give 0. Each input
// beat is held in the input register, then the rule logic and threshold accumulator evaluate it
// and load the result register. One beat is taken every cycle; the only thing that holds the
// input side is a full result register whose beat is not taken. tapscript_mode and the absolute
// lock boundary are written through the cfg port; the user must write them only while no beat
// is in flight, since the block itself does not enforce it.
module script_fragment_type_check #(
	parameter int unsigned MAX_CHILDREN = sfc_pkg::MAX_CHILDREN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [4:0]  opcode,
	input  logic [18:0] type_x,
	input  logic [18:0] type_y,
	input  logic [18:0] type_z,
	input  logic [31:0] threshold_k,
	input  logic [6:0]  child_count,
	input  logic        first_child,
	input  logic        last_child,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic [18:0] result_type
);

	// configuration registers
	logic        tapscript_mode_q;
	logic [31:0] lock_boundary_q;

	// input stage
	logic              valid_s1;
	logic [4:0]        opcode_s1;
	sfc_pkg::ptype_t   x_s1, y_s1, z_s1;
	logic [31:0]       k_s1;
	logic [6:0]        n_s1;
	sfc_pkg::thr_ctl_t ctl_s1;

	// result stage
	logic            result_valid_q;
	sfc_pkg::ptype_t result_type_q;

	logic            is_thresh;
	logic            produce;
	logic            advance;
	logic            thr_step;
	sfc_pkg::ptype_t rule_result;
	sfc_pkg::ptype_t thr_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tapscript_mode_q <= 1'b0;
			lock_boundary_q  <= sfc_pkg::LOCKTIME_RESET;
		end else if (cfg_we) begin
			if (cfg_index == 1'(sfc_pkg::CFG_TAPSCRIPT)) begin
				tapscript_mode_q <= cfg_data[0];
			end else begin
				lock_boundary_q <= cfg_data;
			end
		end
	end

	assign is_thresh = (opcode_s1 == sfc_pkg::OP_THRESH);
	// A threshold child that is not the last one updates state but yields no beat.
	assign produce   = valid_s1 && (!is_thresh || ctl_s1.last);
	// Drain the input stage unless its beat needs the result register and that is blocked.
	assign advance   = valid_s1 && (!produce || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign thr_step  = advance && is_thresh;

	// Hold the input stage; load a fresh beat whenever it is free or draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			opcode_s1 <= opcode;
			x_s1      <= type_x;
			y_s1      <= type_y;
			z_s1      <= type_z;
			k_s1      <= threshold_k;
			n_s1      <= child_count;
			ctl_s1    <= '{first: first_child, last: last_child};
		end
	end

	sfc_rules u_rules (
		.opcode         (opcode_s1),
		.x              (x_s1),
		.y              (y_s1),
		.z              (z_s1),
		.k              (k_s1),
		.tapscript_mode (tapscript_mode_q),
		.lock_boundary  (lock_boundary_q),
		.result         (rule_result)
	);

	sfc_thresh #(
		.MAX_CHILDREN (MAX_CHILDREN)
	) u_thresh (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (thr_step),
		.ctl         (ctl_s1),
		.x           (x_s1),
		.k           (k_s1),
		.child_count (n_s1),
		.result      (thr_result)
	);

	// Result register: load on a producing advance, drop once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && produce) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			result_type_q <= is_thresh ? thr_result : rule_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result_type  = result_type_q;

endmodule

[dv/script_fragment_type_check_tb.sv]
// Testbench for script_fragment_type_check: random and directed fragments against a predictor.
`timescale 1ns / 100ps

module script_fragment_type_check_tb;
	import sfc_pkg::*;

	// Highest opcode value; everything above OP_THRESH names no fragment kind.
	localparam logic [4:0] OP_LAST_CODE = 5'd31;

	// One input beat, field for field as the block's ports carry it.
	typedef struct packed {
		logic [4:0]  op;
		ptype_t      x;
		ptype_t      y;
		ptype_t      z;
		logic [31:0] k;
		logic [6:0]  n;
		logic        first;
		logic        last;
	} fragment_t;

	// Predicts the property set of every accepted fragment and holds the sets still awaited.
	class fragment_type_board;
		ptype_t      awaited[$];
		int unsigned failures;
		bit          tapscript;
		logic [31:0] lock_limit;
		// running state of the threshold being fed
		bit          thr_all_e;
		bit          thr_all_m;
		int unsigned thr_args;
		int unsigned thr_strong;
		logic [4:0]  thr_locks;
		bit          thr_broken;

		function new();
			failures = 0;
			tapscript = 1'b0;
			lock_limit = LOCKTIME_RESET;
			restart_threshold();
		endfunction

		function void restart_threshold();
			thr_all_e = 1'b1;
			thr_all_m = 1'b1;
			thr_args = 0;
			thr_strong = 0;
			thr_locks = 5'(P_KT >> TSHIFT);
			thr_broken = 1'b0;
		endfunction

		function bit holds(ptype_t t, ptype_t m);
			return (t & m) == m;
		endfunction

		function ptype_t gate(bit c, ptype_t v);
			return c ? v : '0;
		endfunction

		// Height and time locks of the same kind may not be mixed.
		function bit lock_clash(ptype_t a, ptype_t b);
			return (holds(a, P_G) && holds(b, P_H)) || (holds(a, P_H) && holds(b, P_G)) ||
				(holds(a, P_I) && holds(b, P_J)) || (holds(a, P_J) && holds(b, P_I));
		endfunction

		function ptype_t o_bit(ptype_t x, ptype_t y);
			return gate(holds(x | y, P_Z), (x | y) & P_O);
		endfunction

		function ptype_t n_bit(ptype_t x, ptype_t y);
			return (x & P_N) | gate(holds(x, P_Z), y & P_N);
		endfunction

		function ptype_t k_bit(ptype_t x, ptype_t y, ptype_t both);
			return gate(holds(both, P_KT) && !lock_clash(x, y), P_KT);
		endfunction

		// Property set of a fragment that answers on its own beat.
		function ptype_t derive_type(fragment_t f);
			ptype_t x;
			ptype_t y;
			ptype_t z;
			ptype_t w;
			bit     sf;
			x = f.x;
			y = f.y;
			z = f.z;
			case (f.op)
				OP_PK_K: return P_K | P_O | P_N | P_U | P_D | P_E | P_M | P_S | P_X | P_KT;
				OP_PK_H: return P_K | P_N | P_U | P_D | P_E | P_M | P_S | P_X | P_KT;
				OP_OLDER: return (f.k[SEQ_TYPE_BIT] ? P_G : P_H) |
					P_B | P_Z | P_F | P_M | P_X | P_KT;
				OP_AFTER: return (f.k >= lock_limit ? P_I : P_J) |
					P_B | P_Z | P_F | P_M | P_X | P_KT;
				OP_SHA256, OP_RIPEMD160, OP_HASH256, OP_HASH160:
					return P_B | P_O | P_N | P_U | P_D | P_M | P_KT;
				OP_JUST_1: return P_B | P_Z | P_U | P_F | P_M | P_X | P_KT;
				OP_JUST_0: return P_B | P_Z | P_U | P_D | P_E | P_M | P_S | P_X | P_KT;
				OP_WRAP_A: return gate(holds(x, P_B), P_W) | (x & P_GHIJK) |
					(x & (P_U | P_D | P_F | P_E | P_M | P_S)) | P_X;
				OP_WRAP_S: return gate(holds(x, P_B | P_O), P_W) | (x & P_GHIJK) |
					(x & (P_U | P_D | P_F | P_E | P_M | P_S | P_X));
				OP_WRAP_C: return gate(holds(x, P_K), P_B) | (x & P_GHIJK) |
					(x & (P_O | P_N | P_D | P_F | P_E | P_M)) | P_U | P_S;
				OP_WRAP_D: return gate(holds(x, P_V | P_Z), P_B) | gate(holds(x, P_Z), P_O) |
					gate(holds(x, P_F), P_E) | (x & P_GHIJK) | (x & (P_M | P_S)) |
					gate(tapscript, P_U) | P_N | P_D | P_X;
				OP_WRAP_V: return gate(holds(x, P_B), P_V) | (x & P_GHIJK) |
					(x & (P_Z | P_O | P_N | P_M | P_S)) | P_F | P_X;
				OP_WRAP_J: return gate(holds(x, P_B | P_N), P_B) | gate(holds(x, P_F), P_E) |
					(x & P_GHIJK) | (x & (P_O | P_U | P_M | P_S)) | P_N | P_D | P_X;
				OP_WRAP_N: return (x & P_GHIJK) |
					(x & (P_B | P_Z | P_O | P_N | P_D | P_F | P_E | P_M | P_S)) | P_U | P_X;
				OP_AND_V: return gate(holds(x, P_V), y & (P_K | P_V | P_B)) | n_bit(x, y) |
					o_bit(x, y) | (x & y & (P_D | P_M | P_Z)) | ((x | y) & P_S) |
					gate(holds(y, P_F) || holds(x, P_S), P_F) | (y & (P_U | P_X)) |
					((x | y) & P_GHIJ) | k_bit(x, y, x & y);
				OP_AND_B: return gate(holds(y, P_W), x & P_B) | o_bit(x, y) | n_bit(x, y) |
					gate(holds(x & y, P_S), x & y & P_E) | (x & y & (P_D | P_Z | P_M)) |
					gate(holds(x & y, P_F) || holds(x, P_S | P_F) || holds(y, P_S | P_F),
						P_F) |
					((x | y) & P_S) | P_U | P_X | ((x | y) & P_GHIJ) | k_bit(x, y, x & y);
				OP_OR_B: return gate(holds(x, P_B | P_D) && holds(y, P_W | P_D), P_B) |
					o_bit(x, y) | gate(holds(x | y, P_S) && holds(x & y, P_E), x & y & P_M) |
					(x & y & (P_Z | P_S | P_E)) | P_D | P_U | P_X | ((x | y) & P_GHIJ) |
					(x & y & P_KT);
				OP_OR_D: return gate(holds(x, P_B | P_D | P_U), y & P_B) |
					gate(holds(y, P_Z), x & P_O) |
					gate(holds(x, P_E) && holds(x | y, P_S), x & y & P_M) |
					(x & y & (P_Z | P_S)) | (y & (P_U | P_F | P_D | P_E)) | P_X |
					((x | y) & P_GHIJ) | (x & y & P_KT);
				OP_OR_C: return gate(holds(x, P_B | P_D | P_U), y & P_V) |
					gate(holds(y, P_Z), x & P_O) |
					gate(holds(x, P_E) && holds(x | y, P_S), x & y & P_M) |
					(x & y & (P_Z | P_S)) | P_F | P_X | ((x | y) & P_GHIJ) | (x & y & P_KT);
				OP_OR_I: return (x & y & (P_V | P_B | P_K | P_U | P_F | P_S)) |
					gate(holds(x & y, P_Z), P_O) | gate(holds(x | y, P_F), (x | y) & P_E) |
					gate(holds(x | y, P_S), x & y & P_M) | ((x | y) & P_D) | P_X |
					((x | y) & P_GHIJ) | (x & y & P_KT);
				OP_ANDOR: begin
					w = x | (y & z);
					sf = holds(x, P_S) || holds(y, P_F);
					return gate(holds(x, P_B | P_D | P_U), y & z & (P_B | P_K | P_V)) |
						(x & y & z & P_Z) | gate(holds(w, P_Z), w & P_O) | (y & z & P_U) |
						gate(sf, z & P_F) | (z & P_D) | gate(sf, z & P_E) |
						gate(holds(x, P_E) && holds(x | y | z, P_S), x & y & z & P_M) |
						(z & (x | y) & P_S) | P_X | ((x | y | z) & P_GHIJ) |
						k_bit(x, y, x & y & z);
				end
				OP_MULTI: return P_B | P_N | P_U | P_D | P_E | P_M | P_S | P_KT;
				OP_MULTI_A: return P_B | P_U | P_D | P_E | P_M | P_S | P_KT;
				default: return '0;
			endcase
		endfunction

		// Fold one threshold child into the running state; answer on the last child.
		function void absorb_child(fragment_t f);
			ptype_t      tl;
			int unsigned add;
			longint      ns;
			longint      nn;
			longint      nk;
			ptype_t      res;
			if (f.first)
				restart_threshold();
			if (!thr_broken) begin
				if (!holds(f.x, f.first ? (P_B | P_D | P_U) : (P_W | P_D | P_U))) begin
					thr_broken = 1'b1;
				end else begin
					tl = ptype_t'(thr_locks) << TSHIFT;
					add = holds(f.x, P_Z) ? 0 : (holds(f.x, P_O) ? 1 : 2);
					if (!holds(f.x, P_E))
						thr_all_e = 1'b0;
					if (!holds(f.x, P_M))
						thr_all_m = 1'b0;
					if (holds(f.x, P_S) && thr_strong < MAX_CHILDREN_DEF)
						thr_strong++;
					thr_args = (thr_args + add > 2) ? 2 : thr_args + add;
					tl = ((tl | f.x) & P_GHIJ) |
						gate(holds(tl & f.x, P_KT) && (f.k <= 1 || !lock_clash(tl, f.x)), P_KT);
					thr_locks = 5'(tl >> TSHIFT);
				end
			end
			if (!f.last)
				return;
			if (thr_broken) begin
				res = '0;
			end else begin
				ns = longint'(thr_strong);
				nn = longint'(f.n);
				nk = nn - longint'(f.k);
				res = P_B | P_D | P_U | gate(thr_args == 0, P_Z) | gate(thr_args == 1, P_O) |
					gate(thr_all_e && ns == nn, P_E) |
					gate(thr_all_e && thr_all_m && ns >= nk, P_M) |
					gate(ns >= nk + 1, P_S) | (ptype_t'(thr_locks) << TSHIFT);
			end
			restart_threshold();
			awaited.push_back(res);
		endfunction

		function void note_fragment(fragment_t f);
			if (f.op == OP_THRESH)
				absorb_child(f);
			else
				awaited.push_back(derive_type(f));
		endfunction

		function void check_type(ptype_t got);
			ptype_t want;
			if (awaited.size() == 0) begin
				failures++;
				$display("%0t: result_type expected none actual %h", $time, got);
				return;
			end
			want = awaited.pop_front();
			if (want !== got) begin
				failures++;
				$display("%0t: result_type expected %h actual %h", $time, want, got);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [4:0]  opcode = '0;
	logic [18:0] type_x = '0;
	logic [18:0] type_y = '0;
	logic [18:0] type_z = '0;
	logic [31:0] threshold_k = '0;
	logic [6:0]  child_count = '0;
	logic        first_child = 1'b0;
	logic        last_child = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [18:0] result_type;

	// Gate for random idling on both channels; cleared for calm stretches and the final phase.
	bit          idling_on = 1'b0;
	int          stall_left = 0;

	fragment_type_board board = new();

	script_fragment_type_check dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.opcode       (opcode),
		.type_x       (type_x),
		.type_y       (type_y),
		.type_z       (type_z),
		.threshold_k  (threshold_k),
		.child_count  (child_count),
		.first_child  (first_child),
		.last_child   (last_child),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_type  (result_type)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: check every beat taken at this edge, then pick next cycle's ready.
	// Values read here are the ones from before the edge, so nothing races the DUT.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.check_type(result_type);
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			// start a stall burst, counting this one
			result_ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Present one beat, hold it until taken, then note it for prediction.
	// Optionally idle for a burst before raising valid.
	task automatic send_fragment(input fragment_t f);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_valid  <= 1'b1;
		opcode      <= f.op;
		type_x      <= f.x;
		type_y      <= f.y;
		type_z      <= f.z;
		threshold_k <= f.k;
		child_count <= f.n;
		first_child <= f.first;
		last_child  <= f.last;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		board.note_fragment(f);
	endtask

	// Drop valid and wait until every awaited result is in, plus the pipeline depth,
	// since a threshold child in flight leaves nothing awaited.
	task automatic settle();
		item_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers on back-to-back cycles; the block is idle here.
	task automatic apply_settings(input bit tap, input logic [31:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= 1'(CFG_TAPSCRIPT);
		cfg_data  <= {31'd0, tap};
		@(posedge clk);
		cfg_index <= 1'(CFG_LOCKTIME);
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.tapscript = tap;
		board.lock_limit = limit;
	endtask

	// Extremes of every field, every kind, and the threshold corner cases.
	task automatic run_directed();
		fragment_t f;
		int        op_i;
		for (op_i = OP_PK_K; op_i <= OP_MULTI_A; op_i++) begin
			f = '0;
			f.op = 5'(op_i);
			f.x = op_i[0] ? ptype_t'($urandom) : '1;
			f.y = op_i[1] ? '0 : '1;
			f.z = ptype_t'($urandom);
			f.k = op_i[0] ? '1 : '0;
			f.n = op_i[0] ? 7'(MAX_CHILDREN_DEF) : '0;
			f.first = op_i[0];
			f.last = !op_i[0];
			send_fragment(f);
		end
		// relative lock by time, absolute lock just below the height/time boundary
		f = '0;
		f.op = OP_OLDER;
		f.k = 32'(1) << SEQ_TYPE_BIT;
		send_fragment(f);
		f.op = OP_AFTER;
		f.k = board.lock_limit - 1;
		send_fragment(f);
		// unknown kind answers with an empty set
		f = '1;
		f.op = OP_LAST_CODE;
		send_fragment(f);
		// first child without B: the rest is ignored and the set comes out empty
		f = '0;
		f.op = OP_THRESH;
		f.x = '1 & ~P_B;
		f.first = 1'b1;
		f.n = 7'd2;
		f.k = 32'd1;
		send_fragment(f);
		f.x = '1;
		f.first = 1'b0;
		f.last = 1'b1;
		send_fragment(f);
		// huge k makes n - k negative when compared signed
		f = '0;
		f.op = OP_THRESH;
		f.x = P_B | P_D | P_U | P_E | P_M | P_S | P_Z | P_KT;
		f.first = 1'b1;
		f.last = 1'b1;
		f.n = 7'(MAX_CHILDREN_DEF);
		f.k = '1;
		send_fragment(f);
		// zero children declared, all properties on the only child
		f.x = '1;
		f.n = '0;
		f.k = '0;
		send_fragment(f);
	endtask

	// One threshold, mostly well formed with random content.
	task automatic send_threshold_set(input int kids);
		fragment_t   f;
		logic [31:0] set_k;
		logic [6:0]  set_n;
		int          i;
		set_n = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, MAX_CHILDREN_DEF))
			: 7'(kids);
		case ($urandom_range(0, 3))
			0: set_k = $urandom;
			1: set_k = $urandom_range(0, 1);
			default: set_k = $urandom_range(0, set_n + 2);
		endcase
		for (i = 0; i < kids; i++) begin
			f.op = OP_THRESH;
			f.first = (i == 0);
			f.last = (i == kids - 1);
			f.x = ptype_t'($urandom);
			// lean toward e, m and s on every child so the counts matter
			if ($urandom_range(0, 1) == 0)
				f.x |= P_E | P_M;
			if ($urandom_range(0, 1) == 0)
				f.x |= P_S;
			if ($urandom_range(0, 24) != 0)
				f.x |= f.first ? (P_B | P_D | P_U) : (P_W | P_D | P_U);
			f.y = ptype_t'($urandom);
			f.z = ptype_t'($urandom);
			// k of each child decides timelock mixing; vary it now and then
			f.k = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 3)) : set_k;
			f.n = set_n;
			send_fragment(f);
		end
	endtask

	// Single beat of any kind, broken threshold beats and unknown opcodes included.
	task automatic send_noise();
		fragment_t f;
		int        pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			f.op = 5'($urandom_range(OP_THRESH + 1, OP_LAST_CODE));
		else if (pick == 1)
			f.op = OP_THRESH;
		else
			f.op = 5'($urandom_range(OP_PK_K, OP_MULTI_A));
		f.x = ptype_t'($urandom);
		f.y = ptype_t'($urandom);
		f.z = ptype_t'($urandom);
		if ($urandom_range(0, 2) == 0)
			f.x |= P_B | P_D | P_U;
		if ($urandom_range(0, 2) == 0)
			f.y |= P_W | P_D;
		case ($urandom_range(0, 5))
			0: f.k = '0;
			1: f.k = '1;
			2: f.k = board.lock_limit;
			3: f.k = board.lock_limit - 1;
			4: f.k = $urandom ^ (32'(1) << SEQ_TYPE_BIT);
			default: f.k = $urandom;
		endcase
		f.n = 7'($urandom_range(0, MAX_CHILDREN_DEF));
		f.first = 1'($urandom_range(0, 1));
		f.last = 1'($urandom_range(0, 1));
		send_fragment(f);
	endtask

	// Random phase: mostly thresholds, the rest single beats; calm and busy stretches alternate
	// unless the whole phase is to run without idling.
	task automatic run_random(input int budget, input bit calm);
		int sent;
		int next_toggle;
		int kids;
		sent = 0;
		next_toggle = 0;
		while (sent < budget) begin
			if (sent >= next_toggle) begin
				idling_on = !calm && $urandom_range(0, 2) != 0;
				next_toggle += 60;
			end
			if ($urandom_range(0, 9) < 6) begin
				kids = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MAX_CHILDREN_DEF)
					: $urandom_range(1, 8);
				send_threshold_set(kids);
				sent += kids;
			end else begin
				send_noise();
				sent++;
			end
		end
	endtask

	initial begin
		// hold reset, release on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_settings(1'b0, LOCKTIME_RESET);
		idling_on = 1'b1;
		run_directed();
		settle();

		run_random(300, 1'b0);
		settle();
		apply_settings(1'b1, '0);
		run_random(300, 1'b0);
		settle();
		apply_settings(1'b0, '1);
		run_random(300, 1'b0);
		settle();
		apply_settings(1'b1, $urandom);
		run_random(300, 1'b0);
		settle();

		// final phase runs flat out on both sides
		apply_settings(1'($urandom_range(0, 1)), LOCKTIME_RESET);
		idling_on = 1'b0;
		run_random(300, 1'b1);
		settle();

		if (board.failures == 0 && board.awaited.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
rtl/sfc_pkg.sv
rtl/sfc_rules.sv
rtl/sfc_thresh.sv
rtl/script_fragment_type_check.sv
dv/script_fragment_type_check_tb.sv
